### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the vertex skinning blend block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### sv/vsb_pkg.sv
// ----------------------------------------------------------------------------
// vsb_pkg
// Shared constants and payload types of the vertex skinning blend block.
// ----------------------------------------------------------------------------
package vsb_pkg;
  localparam int BONE_COUNT_DEF = 64;
  localparam int FRAME_COUNT_MAX_DEF = 64;
  localparam int MAT_WORDS = 12;

  typedef enum logic [1:0] {
    OP_BIND  = 2'd0,
    OP_FRAME = 2'd1,
    OP_SKIN  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [5:0]         frame_slot;
    logic [15:0]        frame_time;
    logic [5:0]         bone;
    logic [3:0]         element;
    logic signed [31:0] value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [16:0]        weight;
    logic               last_term;
  } term_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               clipped;
  } result_t;
endpackage

### sv/vsb_if.sv
// ----------------------------------------------------------------------------
// vsb_term_if / vsb_result_if / vsb_cfg_if
// Valid/ready channels of the vertex skinning blend block.
// ----------------------------------------------------------------------------
interface vsb_term_if import vsb_pkg::*; ();
  logic  valid;
  logic  ready;
  term_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vsb_result_if import vsb_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vsb_cfg_if ();
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/vertex_skinning_blend.sv
// ----------------------------------------------------------------------------
// vertex_skinning_blend
// Linear blend skinning of vertex positions in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// One item is taken at a time; term.ready is high only while the block is
// idle. A matrix write or an unknown op passes through the WRITE state back
// to idle. A skin term with a frame count of zero goes from DIV straight
// back to idle. Any other skin term runs 16 restoring subtract steps to find
// the frame index, then two matrix passes (per row three words of read,
// multiply and add on the one shared 32x32 multiplier, then the translation
// word read and summed), with the XFER state moving the bind result into the
// second pass, and then the three weight products, each in a WMUL and an ACC
// state; the last term of a vertex then goes through EMIT. A skin term whose
// bone is out of range skips the passes and the weighting. While an earlier
// result still waits on result.ready, a last term holds until it leaves.
// Matrix memories are not cleared; reading a word never written gives any value.
`include "assert_macros.svh"
module vertex_skinning_blend import vsb_pkg::*; #(
  parameter int BONE_COUNT      = BONE_COUNT_DEF,
  parameter int FRAME_COUNT_MAX = FRAME_COUNT_MAX_DEF
) (
  input logic          clk,
  input logic          rst,
  vsb_cfg_if.sink      cfg,
  vsb_term_if.sink     term,
  vsb_result_if.source result
);
  localparam int FW = (FRAME_COUNT_MAX > 1) ? $clog2(FRAME_COUNT_MAX) : 1;
  localparam int BIND_DEPTH = BONE_COUNT * MAT_WORDS;
  localparam int FRM_DEPTH  = FRAME_COUNT_MAX * BONE_COUNT * MAT_WORDS;
  localparam int BAW = $clog2(BIND_DEPTH);
  localparam int FAW = $clog2(FRM_DEPTH);
  localparam logic signed [63:0] S32_MAX = 64'sh7FFFFFFF;
  localparam logic signed [63:0] S32_MIN = -64'sh80000000;
  localparam logic signed [63:0] S48_MAX = 64'sh7FFFFFFFFFFF;
  localparam logic signed [63:0] S48_MIN = -64'sh800000000000;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_WRITE = 10'b0000000010,
    S_DIV   = 10'b0000000100,
    S_READ  = 10'b0000001000,
    S_MUL   = 10'b0000010000,
    S_ADD   = 10'b0000100000,
    S_XFER  = 10'b0001000000,
    S_WMUL  = 10'b0010000000,
    S_ACC   = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  logic [31:0] bind_mem [BIND_DEPTH];
  logic [31:0] frm_mem  [FRM_DEPTH];
  logic [31:0] bind_rd, frm_rd;

  state_t state;
  term_t  t;
  logic [6:0] frame_count;
  logic [FW:0] fc;
  logic [15:0] quo;
  logic [FW:0] rem;
  logic [3:0]  step;
  logic [3:0]  widx;
  logic        pass;
  logic [1:0]  col;
  logic [1:0]  lane;
  logic signed [63:0] rowsum;
  logic signed [31:0] vin [3];
  logic signed [31:0] vout [3];
  logic signed [47:0] acc [3];
  logic signed [63:0] prod;
  logic signed [63:0] prodsh;
  logic        clip;
  logic        bone_ok;
  logic        bind_we, frm_we;
  logic        emit_fire;
  logic [BAW-1:0] bind_addr;
  logic [FAW-1:0] frm_addr;
  logic [FW:0] rem_sh;
  logic signed [31:0] rd_word;
  logic signed [31:0] mul_a, mul_b;
  logic signed [47:0] acc_lane;
  logic signed [63:0] rowfin;
  logic signed [63:0] accsum;
  logic [16:0] wsat;
  result_t     res;

  assign fc = (32'(frame_count) > FRAME_COUNT_MAX) ? (FW+1)'(FRAME_COUNT_MAX)
                                                   : (FW+1)'(frame_count);
  assign bone_ok = 32'(t.bone) < BONE_COUNT;
  assign wsat = (t.weight > 17'd65536) ? 17'd65536 : t.weight;
  assign cfg.ready = (state == S_IDLE);
  assign term.ready = (state == S_IDLE);
  assign bind_we = (state == S_WRITE) && (t.op == OP_BIND) && bone_ok &&
                   (t.element < 4'(MAT_WORDS));
  assign frm_we = (state == S_WRITE) && (t.op == OP_FRAME) && bone_ok &&
                  (t.element < 4'(MAT_WORDS)) && (32'(t.frame_slot) < FRAME_COUNT_MAX);
  assign emit_fire = (state == S_EMIT) && t.last_term && (!result.valid || result.ready);

  always_comb begin
    bind_addr = BAW'(32'(t.bone) * MAT_WORDS + 32'(widx));
    frm_addr  = FAW'((32'(rem) * BONE_COUNT + 32'(t.bone)) * MAT_WORDS + 32'(widx));
    if (state == S_WRITE) begin
      frm_addr = FAW'((32'(t.frame_slot) * BONE_COUNT + 32'(t.bone)) * MAT_WORDS
                      + 32'(t.element));
      bind_addr = BAW'(32'(t.bone) * MAT_WORDS + 32'(t.element));
    end
  end

  always_ff @(posedge clk) begin
    if (bind_we)
      bind_mem[bind_addr] <= t.value;
    bind_rd <= bind_mem[bind_addr];
  end

  always_ff @(posedge clk) begin
    if (frm_we)
      frm_mem[frm_addr] <= t.value;
    frm_rd <= frm_mem[frm_addr];
  end

  always_comb begin
    rem_sh = {rem[FW-1:0], quo[15]};
    rd_word = pass ? $signed(frm_rd) : $signed(bind_rd);
    prodsh = prod >>> 16;
    rowfin = rowsum + 64'(rd_word);
    case (lane)
      2'd0: acc_lane = acc[0];
      2'd1: acc_lane = acc[1];
      default: acc_lane = acc[2];
    endcase
    accsum = 64'(acc_lane) + prodsh;
    mul_a = rd_word;
    case (col)
      2'd0: mul_b = vin[0];
      2'd1: mul_b = vin[1];
      default: mul_b = vin[2];
    endcase
    if (state == S_WMUL) begin
      case (lane)
        2'd0: mul_a = vout[0];
        2'd1: mul_a = vout[1];
        default: mul_a = vout[2];
      endcase
      mul_b = $signed({15'd0, wsat});
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      frame_count <= '0;
      acc[0] <= '0; acc[1] <= '0; acc[2] <= '0;
      clip <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg.valid)
            frame_count <= cfg.data;
          if (term.valid) begin
            t <= term.data;
            quo <= term.data.frame_time;
            rem <= '0;
            step <= '0;
            state <= (term.data.op == OP_SKIN) ? S_DIV : S_WRITE;
          end
        end
        S_WRITE: state <= S_IDLE;
        S_DIV: begin
          if (fc == '0) begin
            state <= S_IDLE;
          end else begin
            rem <= (rem_sh >= fc) ? rem_sh - fc : rem_sh;
            quo <= {quo[14:0], 1'b0};
            step <= step + 4'd1;
            if (step == 4'd15) begin
              pass <= 1'b0;
              widx <= '0;
              col <= '0;
              rowsum <= '0;
              vin[0] <= t.pos_x; vin[1] <= t.pos_y; vin[2] <= t.pos_z;
              state <= bone_ok ? S_READ : S_EMIT;
            end
          end
        end
        S_READ: state <= S_MUL;
        S_MUL: begin
          if (col == 2'd3) begin
            if (rowfin > S32_MAX) begin
              vout[widx[3:2]] <= S32_MAX[31:0]; clip <= 1'b1;
            end else if (rowfin < S32_MIN) begin
              vout[widx[3:2]] <= S32_MIN[31:0]; clip <= 1'b1;
            end else begin
              vout[widx[3:2]] <= rowfin[31:0];
            end
            rowsum <= '0;
            col <= '0;
            if (widx == 4'd11) begin
              if (pass) begin
                lane <= '0;
                state <= S_WMUL;
              end else begin
                state <= S_XFER;
              end
            end else begin
              widx <= widx + 4'd1;
              state <= S_READ;
            end
          end else begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          rowsum <= rowsum + prodsh;
          col <= col + 2'd1;
          widx <= widx + 4'd1;
          state <= S_READ;
        end
        S_XFER: begin
          vin[0] <= vout[0]; vin[1] <= vout[1]; vin[2] <= vout[2];
          pass <= 1'b1;
          widx <= '0;
          col <= '0;
          state <= S_READ;
        end
        S_WMUL: state <= S_ACC;
        S_ACC: begin
          if (accsum > S48_MAX) begin
            acc[lane] <= S48_MAX[47:0]; clip <= 1'b1;
          end else if (accsum < S48_MIN) begin
            acc[lane] <= S48_MIN[47:0]; clip <= 1'b1;
          end else begin
            acc[lane] <= accsum[47:0];
          end
          if (lane == 2'd2) begin
            state <= t.last_term ? S_EMIT : S_IDLE;
          end else begin
            lane <= lane + 2'd1;
            state <= S_WMUL;
          end
        end
        S_EMIT: begin
          if (!t.last_term) begin
            state <= S_IDLE;
          end else if (emit_fire) begin
            acc[0] <= '0; acc[1] <= '0; acc[2] <= '0;
            clip <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit_fire) begin
      result.valid <= 1'b1;
      result.data <= res;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_comb begin
    res.clipped = clip;
    res.out_x = (acc[0] > 48'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                (acc[0] < -48'sh80000000) ? -32'sh80000000 : 32'(acc[0]);
    res.out_y = (acc[1] > 48'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                (acc[1] < -48'sh80000000) ? -32'sh80000000 : 32'(acc[1]);
    res.out_z = (acc[2] > 48'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                (acc[2] < -48'sh80000000) ? -32'sh80000000 : 32'(acc[2]);
    if (res.out_x != 32'(acc[0]) || res.out_y != 32'(acc[1]) ||
        res.out_z != 32'(acc[2]))
      res.clipped = 1'b1;
  end

  `ASSERT_IMPL(a_idle_ready, clk, rst, term.ready, state == S_IDLE)
  `ASSERT_IMPL(a_state_onehot, clk, rst, 1'b1, $onehot(state))
  `ASSERT_NEXT(a_result_hold, clk, rst, result.valid && !result.ready, result.valid && $stable(result.data))
  `ASSERT_NEXT(a_acc_clear, clk, rst, emit_fire, acc[0] == '0 && acc[1] == '0 && acc[2] == '0)
endmodule
